// File: src/bpd_pkg.sv
// Package: widths, register indexes and shared types of the block power ducker.
`timescale 1ns / 1ps
package bpd_pkg;

  localparam int MAX_BLOCK_DEF = 64;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BLEN_W     = 7;
  localparam int ENERGY_W   = 37;
  localparam int MEAN_NUM_W = ENERGY_W + 2;
  localparam int POWER_W    = 32;
  localparam int DEN_W      = 49;
  localparam int NUM_W      = 56;
  localparam int GAIN_FRAC  = 40;
  localparam int STEP_W     = 6;

  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(MEAN_NUM_W);
  localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(SAMPLE_W);

  localparam logic [BLEN_W-1:0] BLEN_RST = BLEN_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_DUCK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// File: src/bpd_if.sv
// Interfaces: input pair channel, output word channel and configuration channel.
`timescale 1ns / 1ps
interface bpd_in_if;
  import bpd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sidechain_sample;
  logic signed [SAMPLE_W-1:0] program_sample;
  modport source (output valid, output sidechain_sample, output program_sample, input ready);
  modport sink (input valid, input sidechain_sample, input program_sample, output ready);
endinterface

interface bpd_out_if;
  import bpd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] ducked_sample;
  logic                       last_of_block;
  modport source (output valid, output ducked_sample, output last_of_block, input ready);
  modport sink (input valid, input ducked_sample, input last_of_block, output ready);
endinterface

interface bpd_cfg_if;
  import bpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/bpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bpd_div.sv
// Restoring divider, one quotient bit per cycle, shared by mean and gain.
`timescale 1ns / 1ps
module bpd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpd_pkg::div_req_t               req_i,
  input  logic [bpd_pkg::NUM_W-1:0]       num_i,
  input  logic [bpd_pkg::DEN_W-1:0]       rem_i,
  input  logic [bpd_pkg::DEN_W-1:0]       den_i,
  output logic [bpd_pkg::NUM_W-1:0]       quot_o,
  output logic                            done_o
);
  import bpd_pkg::*;

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] steps_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_i;
      rem_q <= rem_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else if (req_i.start) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      steps_q <= req_i.steps;
    end else if (busy_q) begin
      steps_q <= steps_q - STEP_W'(1);
      if (steps_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

// File: src/block_power_ducker.sv
// Top level: block power ducker, sidechain-driven gain applied per block.
//
//  channel | dir | handshake     | word
//  in_i    | in  | valid / ready | sidechain_sample, program_sample
//  out_o   | out | valid / ready | ducked_sample, last_of_block
//  cfg_i   | in  | valid / ready | index, data (always ready)
//
// A pair is taken whenever valid is high while the block gathers samples.
// At block end of c pairs: the power update (39-step mean divide, two
// multiplies) and the gain denominator, then each output word from a
// 16-step gain divide; no pair is taken until the last word is registered.
// The output register holds a word under stall; intake resumes meanwhile.
// Reset clears energy, count and power; the sample buffer needs no clearing.
`timescale 1ns / 1ps
module block_power_ducker #(
  parameter int MaxBlock = bpd_pkg::MAX_BLOCK_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bpd_in_if.sink   in_i,
  bpd_out_if.source out_o,
  bpd_cfg_if.sink  cfg_i
);
  import bpd_pkg::*;

  localparam int CntW  = $clog2(MaxBlock + 1);
  localparam int AddrW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MEAN   = 4'd1;
  localparam logic [3:0] S_MEAN_W = 4'd2;
  localparam logic [3:0] S_PW_A   = 4'd3;
  localparam logic [3:0] S_PW_B   = 4'd4;
  localparam logic [3:0] S_PW_C   = 4'd5;
  localparam logic [3:0] S_DEN    = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_LD     = 4'd8;
  localparam logic [3:0] S_DIV_W  = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] duck_q, smooth_q;
  logic [BLEN_W-1:0]     blen_q;
  logic [ENERGY_W-1:0]   energy_q;
  logic [CntW-1:0]       cnt_q, blk_cnt_q, k_q;
  logic [POWER_W-1:0]    power_q, mean_q;
  logic [47:0]           prod_a_q;
  logic [48:0]           prod_b_q;
  logic [DEN_W-1:0]      den_q;
  logic                  neg_q;
  logic                  out_valid_q, out_last_q;
  logic [SAMPLE_W-1:0]   out_data_q;

  logic                  in_acc, out_free, blk_end, last_k;
  logic [CntW-1:0]       len_eff, cnt_inc;
  logic signed [31:0]    sc_sq;
  logic [49:0]           pw_acc;
  logic [47:0]           den_prod;
  logic [SAMPLE_W-1:0]   rd_data, mag, q16, res;
  logic [NUM_W-1:0]      gain_num;
  div_req_t              div_req;
  logic [NUM_W-1:0]      div_num, quot;
  logic [DEN_W-1:0]      div_rem, div_den;
  logic                  div_done;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    if (blen_q == '0) begin
      len_eff = CntW'(1);
    end else if (blen_q > BLEN_W'(MaxBlock)) begin
      len_eff = CntW'(MaxBlock);
    end else begin
      len_eff = blen_q[CntW-1:0];
    end
  end

  assign cnt_inc  = cnt_q + CntW'(1);
  assign blk_end  = (cnt_inc >= len_eff);
  assign last_k   = ((k_q + CntW'(1)) == blk_cnt_q);
  assign sc_sq    = in_i.sidechain_sample * in_i.sidechain_sample;
  assign pw_acc   = {2'b00, prod_a_q} + {1'b0, prod_b_q} + 50'd32768;
  assign den_prod = duck_q * power_q;

  // gain divide: numerator |x|*2^40 + D/2, top 40 bits preload the remainder
  assign mag      = rd_data[SAMPLE_W-1] ? (~rd_data + SAMPLE_W'(1)) : rd_data;
  assign gain_num = {mag, {GAIN_FRAC{1'b0}}} + {{(NUM_W-DEN_W+1){1'b0}}, den_q[DEN_W-1:1]};

  always_comb begin
    div_req.start = (state_q == S_MEAN) || (state_q == S_LD);
    div_req.steps = (state_q == S_MEAN) ? MEAN_STEPS : GAIN_STEPS;
    if (state_q == S_MEAN) begin
      div_num = {energy_q, 2'b00, {(NUM_W-MEAN_NUM_W){1'b0}}};
      div_rem = '0;
      div_den = {{(DEN_W-CntW){1'b0}}, blk_cnt_q};
    end else begin
      div_num = {gain_num[SAMPLE_W-1:0], {(NUM_W-SAMPLE_W){1'b0}}};
      div_rem = {{(DEN_W-(NUM_W-SAMPLE_W)){1'b0}}, gain_num[NUM_W-1:SAMPLE_W]};
      div_den = den_q;
    end
  end

  // quotient is at most 2^15; negatives reach -32768, positives clamp
  assign q16 = quot[SAMPLE_W-1:0];
  always_comb begin
    if (neg_q) begin
      res = ~q16 + SAMPLE_W'(1);
    end else if (q16[SAMPLE_W-1]) begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      res = q16;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && blk_end) state_d = S_MEAN;
      S_MEAN:   state_d = S_MEAN_W;
      S_MEAN_W: if (div_done) state_d = S_PW_A;
      S_PW_A:   state_d = S_PW_B;
      S_PW_B:   state_d = S_PW_C;
      S_PW_C:   state_d = S_DEN;
      S_DEN:    state_d = S_RD;
      S_RD:     state_d = S_LD;
      S_LD:     state_d = S_DIV_W;
      S_DIV_W:  if (div_done) state_d = S_PUSH;
      S_PUSH: begin
        if (out_free) state_d = last_k ? S_IDLE : S_RD;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duck_q      <= '0;
      smooth_q    <= '0;
      blen_q      <= BLEN_RST;
      energy_q    <= '0;
      cnt_q       <= '0;
      power_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_DUCK:   duck_q   <= cfg_i.data;
          CFG_SMOOTH: smooth_q <= cfg_i.data;
          CFG_BLEN:   blen_q   <= cfg_i.data[BLEN_W-1:0];
          default:    ;
        endcase
      end
      if (in_acc) begin
        energy_q <= energy_q + {{(ENERGY_W-32){1'b0}}, sc_sq};
        cnt_q    <= cnt_inc;
      end else if (state_q == S_DEN) begin
        energy_q <= '0;
        cnt_q    <= '0;
      end
      if (state_q == S_PW_C) begin
        power_q <= (|pw_acc[49:48]) ? '1 : pw_acc[47:16];
      end
      if (state_q == S_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && blk_end) begin
      blk_cnt_q <= cnt_inc;
    end
    if (state_q == S_MEAN_W && div_done) begin
      mean_q <= (|quot[MEAN_NUM_W-1:POWER_W]) ? '1 : quot[POWER_W-1:0];
    end
    if (state_q == S_PW_A) begin
      prod_a_q <= power_q * smooth_q;
    end
    if (state_q == S_PW_B) begin
      prod_b_q <= mean_q * (17'h10000 - {1'b0, smooth_q});
    end
    if (state_q == S_DEN) begin
      den_q <= DEN_W'({1'b1, {GAIN_FRAC{1'b0}}}) + {1'b0, den_prod};
      k_q   <= '0;
    end
    if (state_q == S_LD) begin
      neg_q <= rd_data[SAMPLE_W-1];
    end
    if (state_q == S_PUSH && out_free) begin
      out_data_q <= res;
      out_last_q <= last_k;
      k_q        <= k_q + CntW'(1);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ducked_sample = out_data_q;
  assign out_o.last_of_block = out_last_q;

  bpd_ram #(
    .Width (SAMPLE_W),
    .Depth (MaxBlock)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_i.program_sample),
    .re_i    (state_q == S_RD),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  bpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .rem_i  (div_rem),
    .den_i  (div_den),
    .quot_o (quot),
    .done_o (div_done)
  );

endmodule

// File: bench/block_power_ducker_test.sv
// Testbench: random and directed pair stimulus with a block-level power and gain predictor.
`timescale 1ns / 1ps
module block_power_ducker_test;
  import bpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam int unsigned RANDOM_PAIRS = 410;
  localparam int unsigned SETTLE = 64;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } duck_word_t;

  class ducker_scoreboard;
    logic [CFG_DATA_W-1:0]      duck_amt = '0;
    logic [CFG_DATA_W-1:0]      smooth_t = '0;
    logic [BLEN_W-1:0]          blen = BLEN_RST;
    logic signed [SAMPLE_W-1:0] held [MAX_BLOCK_DEF];
    logic [ENERGY_W-1:0]        energy = '0;
    int unsigned                fill = 0;
    logic [POWER_W-1:0]         power = '0;
    duck_word_t                 due_words [$];
    int unsigned                failures = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DUCK:   duck_amt = data;
        CFG_SMOOTH: smooth_t = data;
        CFG_BLEN:   blen = data[BLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned block_size();
      if (blen == 0) return 1;
      if (blen > MAX_BLOCK_DEF) return MAX_BLOCK_DEF;
      return blen;
    endfunction

    // Accepted pair: accumulate, and on block end queue the ducked words.
    function void take_pair(logic signed [SAMPLE_W-1:0] sc, logic signed [SAMPLE_W-1:0] pg);
      longint s, x, res;
      longint unsigned mean, acc, t, den, mag, q;
      int unsigned len;
      duck_word_t w;
      len = block_size();
      if (fill >= MAX_BLOCK_DEF) fill = 0;
      held[fill] = pg;
      s = sc;
      energy = ENERGY_W'(energy + ENERGY_W'(s * s));
      fill++;
      if (fill < len) return;
      mean = (64'(energy) << 2) / fill;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      t = smooth_t;
      acc = 64'(power) * t + (64'd65536 - t) * mean + 64'd32768;
      acc = acc >> 16;
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      power = acc[POWER_W-1:0];
      den = (64'd1 << GAIN_FRAC) + 64'(duck_amt) * 64'(power);
      for (int k = 0; k < fill; k++) begin
        x = held[k];
        mag = (x < 0) ? -x : x;
        q = ((mag << GAIN_FRAC) + (den >> 1)) / den;
        res = (x < 0) ? -longint'(q) : longint'(q);
        if (res < -32768) res = -32768;
        if (res > 32767) res = 32767;
        w.sample = SAMPLE_W'(res);
        w.last = (k + 1 == fill);
        due_words.push_back(w);
      end
      energy = '0;
      fill = 0;
    endfunction

    function void check_word(logic signed [SAMPLE_W-1:0] got_s, logic got_last);
      duck_word_t w;
      if (due_words.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected word: sample %0d last %0b", got_s, got_last);
        return;
      end
      w = due_words.pop_front();
      if (got_s !== w.sample || got_last !== w.last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("word mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                   w.sample, w.last, got_s, got_last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bpd_in_if  pair_ch ();
  bpd_out_if word_ch ();
  bpd_cfg_if cfg_ch ();

  block_power_ducker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_ch),
    .out_o  (word_ch),
    .cfg_i  (cfg_ch)
  );

  ducker_scoreboard ledger = new();
  bit               calm_in = 1'b0;
  bit               calm_out = 1'b0;
  int unsigned      hold_cycles = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(int unsigned shift);
    case ($urandom_range(0, 19))
      0: return S_MAX;
      1: return S_MIN;
      default: return $signed(SAMPLE_W'($urandom)) >>> shift;
    endcase
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    ledger.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] duck, smooth, blen_word,
                              input bit poke_spare);
    put_reg(CFG_DUCK, duck);
    put_reg(CFG_SMOOTH, smooth);
    put_reg(CFG_BLEN, blen_word);
    if (poke_spare) put_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] sc, pg);
    int unsigned gap;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_ch.valid            <= 1'b1;
    pair_ch.sidechain_sample <= sc;
    pair_ch.program_sample   <= pg;
    do @(posedge clk_i); while (!pair_ch.ready);
    ledger.take_pair(sc, pg);
  endtask

  task automatic drain(input int unsigned settle);
    pair_ch.valid <= 1'b0;
    while (ledger.due_words.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Word receiver: random per-word hold-off, plus a long hold when requested.
  initial begin
    int unsigned gap;
    gap = 0;
    word_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (word_ch.valid && word_ch.ready) begin
        ledger.check_word(word_ch.ducked_sample, word_ch.last_of_block);
        gap = draw_gap(calm_out);
      end
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        word_ch.ready <= 1'b0;
        gap--;
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned random_sent, n, eff, shift, phase;
    logic [CFG_DATA_W-1:0] duck, smooth, blen_word;
    int unsigned len_pick;
    rst_ni                   <= 1'b0;
    pair_ch.valid            <= 1'b0;
    pair_ch.sidechain_sample <= '0;
    pair_ch.program_sample   <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= CFG_DUCK;
    cfg_ch.data              <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unity gain, one-pair blocks
    program_regs(16'd0, 16'd0, 16'd1, 1'b0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd1);
    drain(SETTLE);

    // full ducking, saturated mean, spare index write ignored
    program_regs(16'hFFFF, 16'd0, 16'd1, 1'b1);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(16'sd0, S_MIN);
    send_pair(16'sd16384, -16'sd1);
    drain(SETTLE);

    // zero length acts as one; slowest smoothing
    program_regs(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MAX, 16'sh8001);
    send_pair(S_MIN, S_MIN);
    drain(SETTLE);

    // length lowered mid-block: next pair closes a block of three
    program_regs(16'd300, 16'd40000, 16'd3, 1'b0);
    send_pair(16'sd1000, 16'sd1234);
    send_pair(-16'sd2000, -16'sd4321);
    drain(SETTLE);
    program_regs(16'd300, 16'd40000, 16'd1, 1'b0);
    send_pair(S_MAX, S_MIN);
    drain(SETTLE);

    // upper data bits of the length write are dropped
    program_regs(16'd1000, 16'd0, 16'hFF82, 1'b0);
    send_pair(16'sd12000, 16'sd30000);
    send_pair(-16'sd12000, -16'sd30000);
    send_pair(16'sd500, S_MAX);
    send_pair(S_MIN, S_MIN);
    drain(SETTLE);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_PAIRS) begin
      case ($urandom_range(0, 3))
        0: duck = 16'd0;
        1: duck = 16'hFFFF;
        2: duck = CFG_DATA_W'($urandom_range(1, 255));
        default: duck = CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: smooth = 16'd0;
        1: smooth = 16'hFFFF;
        default: smooth = CFG_DATA_W'($urandom);
      endcase
      len_pick = $urandom_range(0, 19);
      if (len_pick == 0) blen_word = 16'd0;
      else if (len_pick == 1) blen_word = CFG_DATA_W'($urandom_range(65, 127));
      else if (len_pick <= 3) blen_word = CFG_DATA_W'($urandom_range(33, 64));
      else if (len_pick <= 6) blen_word = CFG_DATA_W'($urandom_range(9, 32));
      else blen_word = CFG_DATA_W'($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) blen_word[CFG_DATA_W-1:BLEN_W] = 9'($urandom);
      if (phase == 0) blen_word = 16'd127;
      if (phase == 1) blen_word = 16'd64;
      if (phase == 2) blen_word = 16'd4;
      program_regs(duck, smooth, blen_word, $urandom_range(0, 9) == 0);
      eff = ledger.block_size();
      if (eff >= 33) n = eff;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * eff);
      else n = eff * $urandom_range(1, 3);
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        n = 6 * eff;
        calm_in = 1'b1;
        hold_cycles = HOLD_CYCLES;
      end
      shift = $urandom_range(0, 15);
      repeat (n) send_pair(draw_sample(shift), draw_sample(0));
      random_sent += n;
      drain(SETTLE);
      phase++;
    end

    drain(2 * SETTLE);
    if (ledger.failures == 0 && ledger.due_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
